FILE: hdl/drive_mix_and_launcher_pid_top_defines.svh
// ----------------------------------------------------------------------------
// drive mix and launcher pid: assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DRIVE_MIX_AND_LAUNCHER_PID_TOP_DEFINES_SVH
`define DRIVE_MIX_AND_LAUNCHER_PID_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DMLP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmlp check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define DMLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmlp check failed one cycle later");

`endif

FILE: hdl/dmlp_pkg.sv
// ----------------------------------------------------------------------------
// dmlp_pkg
// types and constants shared by the drive mix and launcher pid block
// ----------------------------------------------------------------------------
`default_nettype none

package dmlp_pkg;

  localparam int AXIS_W    = 8;
  localparam int DRIVE_W   = 9;
  localparam int SPEED_W   = 16;
  localparam int DB_W      = 7;
  localparam int GAIN_W    = 8;
  localparam int LIM_W     = 7;
  localparam int TGT_W     = 11;
  localparam int GAIN_FRAC = 8;

  localparam int MANUAL_PCT = 100;
  localparam int SLOW_PCT   = 25;

  localparam int RESULT_W = 2 * DRIVE_W + 1 + 2 + SPEED_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DEADBAND = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CLAMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CLAMP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_TARGET    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_TARGET     = 3'd7;

  localparam logic [DB_W-1:0]   RST_DRIVE_DEADBAND = 7'd5;
  localparam logic [GAIN_W-1:0] RST_GAIN_P         = 8'd128;
  localparam logic [GAIN_W-1:0] RST_GAIN_I         = 8'd26;
  localparam logic [GAIN_W-1:0] RST_GAIN_D         = 8'd26;
  localparam logic [LIM_W-1:0]  RST_INTEGRAL_CLAMP = 7'd10;
  localparam logic [LIM_W-1:0]  RST_OUTPUT_CLAMP   = 7'd100;
  localparam logic [TGT_W-1:0]  RST_NEAR_TARGET    = 11'd28;
  localparam logic [TGT_W-1:0]  RST_FAR_TARGET     = 11'd79;

  typedef struct packed {
    logic [DB_W-1:0]   drive_deadband;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [LIM_W-1:0]  integral_clamp;
    logic [LIM_W-1:0]  output_clamp;
    logic [TGT_W-1:0]  near_target_mm;
    logic [TGT_W-1:0]  far_target_mm;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_NEAR   = 2'd1,
    MODE_FAR    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ACT_STOP = 2'd0,
    ACT_RUN  = 2'd1,
    ACT_KEEP = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    MUL_GI_ERR = 2'd0,
    MUL_GP_ERR = 2'd1,
    MUL_GI_ACC = 2'd2,
    MUL_GD_DER = 2'd3
  } mul_sel_e;

  typedef enum logic [1:0] {
    SUM_HOLD        = 2'd0,
    SUM_LOAD_SCALED = 2'd1,
    SUM_ADD         = 2'd2,
    SUM_ADD_SCALED  = 2'd3
  } sum_op_e;

  typedef struct packed {
    logic     mul_en;
    mul_sel_e mul_sel;
    sum_op_e  sum_op;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DECIDE   = 3'd1,
    ST_MUL_IACC = 3'd2,
    ST_MUL_P    = 3'd3,
    ST_MUL_I    = 3'd4,
    ST_MUL_D    = 3'd5,
    ST_SUM_D    = 3'd6,
    ST_DONE     = 3'd7
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/dmlp_channels.sv
// ----------------------------------------------------------------------------
// dmlp channels
// valid/ready channel interfaces for ticks, results and configuration
// ----------------------------------------------------------------------------
`default_nettype none

interface dmlp_tick_if #(
  parameter int DIST_BITS = 11
);
  logic                                valid;
  logic                                ready;
  logic signed [dmlp_pkg::AXIS_W-1:0]  axis_forward;
  logic signed [dmlp_pkg::AXIS_W-1:0]  axis_turn;
  logic                                btn_intake;
  logic                                btn_fire;
  logic                                btn_up;
  logic                                btn_down;
  logic                                btn_left;
  logic [DIST_BITS-1:0]                distance_mm;

  modport source (
    output valid, axis_forward, axis_turn, btn_intake, btn_fire, btn_up,
           btn_down, btn_left, distance_mm,
    input  ready
  );
  modport sink (
    input  valid, axis_forward, axis_turn, btn_intake, btn_fire, btn_up,
           btn_down, btn_left, distance_mm,
    output ready
  );
endinterface

interface dmlp_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [dmlp_pkg::DRIVE_W-1:0] left_drive;
  logic signed [dmlp_pkg::DRIVE_W-1:0] right_drive;
  logic                                intake_run;
  logic [1:0]                          launcher_action;
  logic signed [dmlp_pkg::SPEED_W-1:0] launcher_speed;
  logic [1:0]                          launcher_mode;

  modport source (
    output valid, left_drive, right_drive, intake_run, launcher_action,
           launcher_speed, launcher_mode,
    input  ready
  );
  modport sink (
    input  valid, left_drive, right_drive, intake_run, launcher_action,
           launcher_speed, launcher_mode,
    output ready
  );
endinterface

interface dmlp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dmlp_pkg::CFG_IDX_W-1:0]    index;
  logic [dmlp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dmlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// dmlp_cfg_regs
// configuration register file, written one register per beat
// ----------------------------------------------------------------------------
`default_nettype none

module dmlp_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  dmlp_cfg_if.sink       cfg,
  output dmlp_pkg::cfg_t regs
);
  import dmlp_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.drive_deadband <= RST_DRIVE_DEADBAND;
      regs.gain_p         <= RST_GAIN_P;
      regs.gain_i         <= RST_GAIN_I;
      regs.gain_d         <= RST_GAIN_D;
      regs.integral_clamp <= RST_INTEGRAL_CLAMP;
      regs.output_clamp   <= RST_OUTPUT_CLAMP;
      regs.near_target_mm <= RST_NEAR_TARGET;
      regs.far_target_mm  <= RST_FAR_TARGET;
    end else if (cfg.valid) begin
      // upper data bits beyond a register's width are dropped
      unique case (cfg.index)
        REG_DRIVE_DEADBAND: regs.drive_deadband <= cfg.data[DB_W-1:0];
        REG_GAIN_P:         regs.gain_p         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_I:         regs.gain_i         <= cfg.data[GAIN_W-1:0];
        REG_GAIN_D:         regs.gain_d         <= cfg.data[GAIN_W-1:0];
        REG_INTEGRAL_CLAMP: regs.integral_clamp <= cfg.data[LIM_W-1:0];
        REG_OUTPUT_CLAMP:   regs.output_clamp   <= cfg.data[LIM_W-1:0];
        REG_NEAR_TARGET:    regs.near_target_mm <= cfg.data[TGT_W-1:0];
        REG_FAR_TARGET:     regs.far_target_mm  <= cfg.data[TGT_W-1:0];
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dmlp_drive_mix.sv
// ----------------------------------------------------------------------------
// dmlp_drive_mix
// arcade mixing of the two stick axes with a magnitude deadband
// ----------------------------------------------------------------------------
`default_nettype none

module dmlp_drive_mix (
  input  logic signed [dmlp_pkg::AXIS_W-1:0]  axis_forward,
  input  logic signed [dmlp_pkg::AXIS_W-1:0]  axis_turn,
  input  logic        [dmlp_pkg::DB_W-1:0]    deadband,
  output logic signed [dmlp_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [dmlp_pkg::DRIVE_W-1:0] right_drive
);
  import dmlp_pkg::*;

  // one extra bit so the magnitude of -256 fits
  localparam int MAG_W = DRIVE_W + 1;

  logic signed [DRIVE_W-1:0] diff;
  logic signed [DRIVE_W-1:0] total;
  logic signed [MAG_W-1:0]   diff_x;
  logic signed [MAG_W-1:0]   total_x;
  logic        [MAG_W-1:0]   diff_mag;
  logic        [MAG_W-1:0]   total_mag;
  logic        [MAG_W-1:0]   db_x;

  assign diff    = DRIVE_W'(axis_forward) - DRIVE_W'(axis_turn);
  assign total   = DRIVE_W'(axis_forward) + DRIVE_W'(axis_turn);
  assign diff_x  = MAG_W'(diff);
  assign total_x = MAG_W'(total);

  assign diff_mag  = diff_x[MAG_W-1]  ? MAG_W'(-diff_x)  : MAG_W'(diff_x);
  assign total_mag = total_x[MAG_W-1] ? MAG_W'(-total_x) : MAG_W'(total_x);
  assign db_x      = MAG_W'(deadband);

  assign left_drive  = (diff_mag  < db_x) ? '0 : diff;
  assign right_drive = (total_mag < db_x) ? '0 : total;

endmodule

`default_nettype wire

FILE: hdl/dmlp_pid_mac.sv
// ----------------------------------------------------------------------------
// dmlp_pid_mac
// shared gain multiplier with a registered product and a sum accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module dmlp_pid_mac #(
  parameter int ERR_W     = 12,
  parameter int DER_W     = 13,
  parameter int ACC_W     = 16,
  parameter int FRAC_BITS = 8,
  parameter int SUM_W     = 31
) (
  input  logic                              clk,
  input  dmlp_pkg::mac_ctrl_t               ctrl,
  input  logic        [dmlp_pkg::GAIN_W-1:0] gain_p,
  input  logic        [dmlp_pkg::GAIN_W-1:0] gain_i,
  input  logic        [dmlp_pkg::GAIN_W-1:0] gain_d,
  input  logic signed [ERR_W-1:0]           err,
  input  logic signed [DER_W-1:0]           der,
  input  logic signed [ACC_W-1:0]           acc,
  output logic signed [SUM_W-1:0]           prod_scaled,
  output logic signed [SUM_W-1:0]           sum
);
  import dmlp_pkg::*;

  localparam int OP_W   = (DER_W > ACC_W) ? DER_W : ACC_W;
  localparam int PROD_W = OP_W + GAIN_W + 1;

  logic        [GAIN_W-1:0] gain_sel;
  logic signed [OP_W-1:0]   opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_x;

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_GI_ERR: begin
        gain_sel = gain_i;
        opnd     = OP_W'(err);
      end
      MUL_GP_ERR: begin
        gain_sel = gain_p;
        opnd     = OP_W'(err);
      end
      MUL_GI_ACC: begin
        gain_sel = gain_i;
        opnd     = OP_W'(acc);
      end
      MUL_GD_DER: begin
        gain_sel = gain_d;
        opnd     = OP_W'(der);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= $signed({1'b0, gain_sel}) * opnd;
    end
  end

  assign prod_x      = SUM_W'(prod);
  // error terms carry the Q.FRAC_BITS scale, the integral term already has it
  assign prod_scaled = prod_x <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    unique case (ctrl.sum_op)
      SUM_HOLD:        sum <= sum;
      SUM_LOAD_SCALED: sum <= prod_scaled;
      SUM_ADD:         sum <= sum + prod_x;
      SUM_ADD_SCALED:  sum <= sum + prod_scaled;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/drive_mix_and_launcher_pid_top.sv
// ----------------------------------------------------------------------------
// drive_mix_and_launcher_pid_top
// per-tick drive mixer, intake control and three-mode launcher pid
// ----------------------------------------------------------------------------
// usage:
//   tick   : one beat per control tick (stick axes, five buttons, distance)
//   result : one beat per tick (drive sides, intake, launcher action, speed,
//            mode after the tick)
//   cfg    : register writes, index 0..7 in the order drive_deadband, gain_p,
//            gain_i, gain_d, integral_clamp, output_clamp, near, far target;
//            always ready, write only while the block is idle
// sequencing:
//   a tick is taken only in the idle state, then the block is busy.
//   stop, manual and mode-switch ticks go from decide straight to done;
//   pid ticks first make four passes through the one shared gain multiplier,
//   each product registered before it is accumulated.
//   a finished result sits in the output register; the next tick is taken
//   meanwhile and its result waits in the done state until the receiver
//   takes the pending beat.
// reset (synchronous, active high): registers back to defaults, manual mode,
//   pid integral and last error cleared, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_mix_and_launcher_pid_top #(
  parameter int DIST_BITS = 11,
  parameter int FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  dmlp_cfg_if.sink      cfg,
  dmlp_tick_if.sink     tick,
  dmlp_result_if.source result
);
  import dmlp_pkg::*;

  // compare width covers both the distance and the 11 bit targets
  localparam int CMP_W = ((DIST_BITS > TGT_W) ? DIST_BITS : TGT_W) + 1;
  // pid only runs with distance above target, so error is negative and fits
  localparam int ERR_W = DIST_BITS + 1;
  localparam int DER_W = DIST_BITS + 2;
  // integral is bounded by 127 whole units in Q.FRAC_BITS
  localparam int ACC_W = FRAC_BITS + 8;
  localparam int SUM_W = DIST_BITS + FRAC_BITS + 12;

  localparam logic [SPEED_W-1:0] MANUAL_SPEED = SPEED_W'(MANUAL_PCT * (1 << FRAC_BITS));
  localparam logic [SPEED_W-1:0] SLOW_SPEED   = SPEED_W'(SLOW_PCT * (1 << FRAC_BITS));

  // configuration
  cfg_t cfg_q;

  dmlp_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_q)
  );

  // sequencer and controller state
  state_e state;
  state_e state_next;
  mode_e  mode;
  mode_e  mode_next;

  logic signed [ERR_W-1:0] last_err;
  logic signed [ACC_W-1:0] acc;

  // tick latched at accept
  logic signed [AXIS_W-1:0] in_fwd;
  logic signed [AXIS_W-1:0] in_turn;
  logic                     in_intake;
  logic                     in_fire;
  logic                     in_up;
  logic                     in_down;
  logic                     in_left;
  logic [DIST_BITS-1:0]     in_dist;

  // decision held for the pid passes and the done state
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DER_W-1:0]  der_r;
  action_e                  act_r;
  logic [SPEED_W-1:0]       speed_r;
  logic                     pid_r;

  // output register
  logic                       out_valid;
  logic signed [DRIVE_W-1:0]  out_left;
  logic signed [DRIVE_W-1:0]  out_right;
  logic                       out_intake;
  logic [1:0]                 out_action;
  logic signed [SPEED_W-1:0]  out_speed;
  logic [1:0]                 out_mode;

  // handshake and datapath control
  logic      in_ready;
  logic      out_load;
  mac_ctrl_t mac_ctrl;

  assign tick.ready = in_ready;

  always_ff @(posedge clk) begin
    if (in_ready && tick.valid) begin
      in_fwd    <= tick.axis_forward;
      in_turn   <= tick.axis_turn;
      in_intake <= tick.btn_intake;
      in_fire   <= tick.btn_fire;
      in_up     <= tick.btn_up;
      in_down   <= tick.btn_down;
      in_left   <= tick.btn_left;
      in_dist   <= tick.distance_mm;
    end
  end

  // mode machine and pid entry, evaluated in the decide state
  logic [TGT_W-1:0]        target;
  logic [CMP_W-1:0]        dist_x;
  logic [CMP_W-1:0]        tgt_x;
  logic signed [CMP_W-1:0] err_full;
  logic signed [ERR_W-1:0] err_w;
  logic signed [DER_W-1:0] der_w;
  action_e                 dec_act;
  logic [SPEED_W-1:0]      dec_speed;
  logic                    pid_go;

  assign target   = (mode == MODE_NEAR) ? cfg_q.near_target_mm : cfg_q.far_target_mm;
  assign dist_x   = CMP_W'(in_dist);
  assign tgt_x    = CMP_W'(target);
  assign err_full = $signed(tgt_x - dist_x);
  assign err_w    = err_full[ERR_W-1:0];
  assign der_w    = DER_W'(err_w) - DER_W'(last_err);

  always_comb begin
    mode_next = mode;
    dec_act   = ACT_STOP;
    dec_speed = '0;
    pid_go    = 1'b0;
    if (mode == MODE_MANUAL) begin
      priority if (in_fire) begin
        dec_act   = ACT_RUN;
        dec_speed = MANUAL_SPEED;
      end else if (in_down) begin
        mode_next = MODE_NEAR;
        dec_act   = ACT_KEEP;
      end else if (in_left) begin
        mode_next = MODE_FAR;
        dec_act   = ACT_KEEP;
      end else begin
        dec_act = ACT_STOP;
      end
    end else begin
      priority if (in_fire) begin
        dec_act   = ACT_RUN;
        dec_speed = SLOW_SPEED;
      end else if (in_up) begin
        mode_next = MODE_MANUAL;
        dec_act   = ACT_KEEP;
      end else if (mode == MODE_NEAR && in_left) begin
        mode_next = MODE_FAR;
        dec_act   = ACT_KEEP;
      end else if (mode == MODE_FAR && in_down) begin
        mode_next = MODE_NEAR;
        dec_act   = ACT_KEEP;
      end else if (dist_x > tgt_x) begin
        // error is strictly negative here, so the zero band never applies
        pid_go  = 1'b1;
        dec_act = ACT_RUN;
      end else begin
        dec_act = ACT_STOP;
      end
    end
  end

  // shared multiplier and accumulator
  logic signed [SUM_W-1:0] prod_scaled;
  logic signed [SUM_W-1:0] mac_sum;

  dmlp_pid_mac #(
    .ERR_W     (ERR_W),
    .DER_W     (DER_W),
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS),
    .SUM_W     (SUM_W)
  ) u_mac (
    .clk         (clk),
    .ctrl        (mac_ctrl),
    .gain_p      (cfg_q.gain_p),
    .gain_i      (cfg_q.gain_i),
    .gain_d      (cfg_q.gain_d),
    .err         (err_r),
    .der         (der_r),
    .acc         (acc),
    .prod_scaled (prod_scaled),
    .sum         (mac_sum)
  );

  // integral update: acc + floor(gain_i * err * one / 256), then clamp
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] ilim;
  logic signed [SUM_W-1:0] acc_clamped;

  assign acc_sum = SUM_W'(acc) + (prod_scaled >>> GAIN_FRAC);
  assign ilim    = $signed(SUM_W'(cfg_q.integral_clamp) << FRAC_BITS);

  always_comb begin
    priority if (acc_sum > ilim) begin
      acc_clamped = ilim;
    end else if (acc_sum < -ilim) begin
      acc_clamped = -ilim;
    end else begin
      acc_clamped = acc_sum;
    end
  end

  // pid output: floor shift of the exact sum, then clamp
  logic signed [SUM_W-1:0] sum_q;
  logic signed [SUM_W-1:0] olim;
  logic signed [SUM_W-1:0] sum_clamped;
  logic [SPEED_W-1:0]      pid_speed;

  assign sum_q = mac_sum >>> GAIN_FRAC;
  assign olim  = $signed(SUM_W'(cfg_q.output_clamp) << FRAC_BITS);

  always_comb begin
    priority if (sum_q > olim) begin
      sum_clamped = olim;
    end else if (sum_q < -olim) begin
      sum_clamped = -olim;
    end else begin
      sum_clamped = sum_q;
    end
  end

  assign pid_speed = sum_clamped[SPEED_W-1:0];

  // drive mixing from the latched axes
  logic signed [DRIVE_W-1:0] mix_left;
  logic signed [DRIVE_W-1:0] mix_right;

  dmlp_drive_mix u_mix (
    .axis_forward (in_fwd),
    .axis_turn    (in_turn),
    .deadband     (cfg_q.drive_deadband),
    .left_drive   (mix_left),
    .right_drive  (mix_right)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    out_load         = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.mul_sel = MUL_GI_ERR;
    mac_ctrl.sum_op  = SUM_HOLD;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (tick.valid) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = pid_go ? ST_MUL_IACC : ST_DONE;
      end
      ST_MUL_IACC: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.mul_sel = MUL_GI_ERR;
        state_next       = ST_MUL_P;
      end
      ST_MUL_P: begin
        // integral is written this cycle from gain_i * err
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.mul_sel = MUL_GP_ERR;
        state_next       = ST_MUL_I;
      end
      ST_MUL_I: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.mul_sel = MUL_GI_ACC;
        mac_ctrl.sum_op  = SUM_LOAD_SCALED;
        state_next       = ST_MUL_D;
      end
      ST_MUL_D: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.mul_sel = MUL_GD_DER;
        mac_ctrl.sum_op  = SUM_ADD;
        state_next       = ST_SUM_D;
      end
      ST_SUM_D: begin
        mac_ctrl.sum_op = SUM_ADD_SCALED;
        state_next      = ST_DONE;
      end
      ST_DONE: begin
        // hold here while the previous result is still pending
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_MANUAL;
      last_err <= '0;
      acc      <= '0;
    end else begin
      if (state == ST_DECIDE) begin
        mode <= mode_next;
      end
      if (state == ST_MUL_P) begin
        acc      <= acc_clamped[ACC_W-1:0];
        last_err <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      err_r   <= err_w;
      der_r   <= der_w;
      act_r   <= dec_act;
      speed_r <= dec_speed;
      pid_r   <= pid_go;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left   <= mix_left;
      out_right  <= mix_right;
      out_intake <= in_intake;
      out_action <= act_r;
      out_speed  <= pid_r ? pid_speed : speed_r;
      out_mode   <= mode;
    end
  end

  assign result.valid           = out_valid;
  assign result.left_drive      = out_left;
  assign result.right_drive     = out_right;
  assign result.intake_run      = out_intake;
  assign result.launcher_action = out_action;
  assign result.launcher_speed  = out_speed;
  assign result.launcher_mode   = out_mode;

endmodule

`default_nettype wire

FILE: hdl/dmlp_checker.sv
// ----------------------------------------------------------------------------
// dmlp_checker
// port-level assertions for the drive mix and launcher pid block
// ----------------------------------------------------------------------------
`default_nettype none

`include "drive_mix_and_launcher_pid_top_defines.svh"

module dmlp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    launcher_action,
  input logic [dmlp_pkg::SPEED_W-1:0]  launcher_speed,
  input logic [dmlp_pkg::RESULT_W-1:0] out_word
);
  import dmlp_pkg::*;

  // a tick beat always leaves the block busy in the cycle after the beat
  `DMLP_ASSERT_NEXT(a_busy_after_tick, clk, rst, in_valid && in_ready, !in_ready)

  // speed is only nonzero when the launcher is driven
  `DMLP_ASSERT_SAME(a_speed_idle_zero, clk, rst, out_valid && (launcher_action != ACT_RUN), launcher_speed == '0)

  // stalled result beat stays up and unchanged
  `DMLP_ASSERT_NEXT(a_result_held, clk, rst, out_valid && !out_ready, out_valid)
  `DMLP_ASSERT_NEXT(a_result_stable, clk, rst, out_valid && !out_ready, $stable(out_word))

endmodule

bind drive_mix_and_launcher_pid_top dmlp_checker u_dmlp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (tick.valid),
  .in_ready        (tick.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .launcher_action (result.launcher_action),
  .launcher_speed  (result.launcher_speed),
  .out_word        ({result.left_drive, result.right_drive, result.intake_run,
                     result.launcher_action, result.launcher_speed,
                     result.launcher_mode})
);

`default_nettype wire
